// ----- src/tfn_pkg.sv -----
// shared widths and types for the triangle face normal pipeline
package tfn_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int EDGE_W      = COORD_WIDTH + 1;
    localparam int PROD_W      = 2 * EDGE_W;
    localparam int CROSS_W     = PROD_W + 1;
    localparam int MAG_W       = PROD_W;
    localparam int SQ_W        = 2 * MAG_W;
    localparam int SUM_W       = SQ_W + 2;
    localparam int ROOT_W      = SUM_W / 2;
    localparam int FRAC_W      = 14;
    localparam int Q_W         = FRAC_W + 2;
    localparam int NUM_W       = ROOT_W + Q_W + 1;
    localparam int OUT_W       = 16;
    localparam logic [Q_W-1:0] NORM_ONE = Q_W'(1) << FRAC_W;

    typedef logic [MAG_W-1:0] mag_t;

    typedef struct packed {
        logic [2:0][MAG_W-1:0] mag;
        logic [2:0]            neg;
        logic                  deg;
    } side_t;

    typedef struct packed {
        logic [2:0] neg;
        logic       deg;
    } sign_t;

endpackage

// ----- src/triangle_face_normal.sv -----
// top level: unit face normal of one triangle per item
//
// usage: drive the nine vertex coordinates (signed Q4.12) and raise start;
// an item is taken at every rising edge where start is high and busy is low.
// busy stays low, so a new triangle can be taken in every cycle.
// the result (normal_x/y/z in signed Q1.14, degenerate flag) is on the
// result ports for exactly one cycle, marked by done, once the item has
// passed the edge, product, cross product, square and sum registers, the
// square root pipeline (one root bit per stage), the divider pipeline
// (one quotient bit per stage) and the output register. throughput is
// one item per cycle.
// a zero cross product gives a zero normal with degenerate set.
// reset clears all valid bits, so no done pulse follows reset until an item
// has been taken. the receiver cannot stall; done is never held off.
module triangle_face_normal (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [tfn_pkg::COORD_WIDTH-1:0] v0_x,
    input  logic signed [tfn_pkg::COORD_WIDTH-1:0] v0_y,
    input  logic signed [tfn_pkg::COORD_WIDTH-1:0] v0_z,
    input  logic signed [tfn_pkg::COORD_WIDTH-1:0] v1_x,
    input  logic signed [tfn_pkg::COORD_WIDTH-1:0] v1_y,
    input  logic signed [tfn_pkg::COORD_WIDTH-1:0] v1_z,
    input  logic signed [tfn_pkg::COORD_WIDTH-1:0] v2_x,
    input  logic signed [tfn_pkg::COORD_WIDTH-1:0] v2_y,
    input  logic signed [tfn_pkg::COORD_WIDTH-1:0] v2_z,
    output logic                                done,
    output logic signed [tfn_pkg::OUT_W-1:0]    normal_x,
    output logic signed [tfn_pkg::OUT_W-1:0]    normal_y,
    output logic signed [tfn_pkg::OUT_W-1:0]    normal_z,
    output logic                                degenerate
);

    localparam int EW = tfn_pkg::EDGE_W;
    localparam int PW = tfn_pkg::PROD_W;
    localparam int CW = tfn_pkg::CROSS_W;
    localparam int MW = tfn_pkg::MAG_W;
    localparam int SQW = tfn_pkg::SQ_W;
    localparam int SW = tfn_pkg::SUM_W;
    localparam int QW = tfn_pkg::Q_W;
    localparam int OW = tfn_pkg::OUT_W;

    assign busy = 1'b0;

    // stage 1: edges
    logic signed [EW-1:0] e1_reg [3];
    logic signed [EW-1:0] e2_reg [3];
    logic signed [EW-1:0] e1_next [3];
    logic signed [EW-1:0] e2_next [3];
    logic                 s1_valid_reg;

    always_comb
    begin
        e1_next[0] = EW'(v1_x) - EW'(v0_x);
        e1_next[1] = EW'(v1_y) - EW'(v0_y);
        e1_next[2] = EW'(v1_z) - EW'(v0_z);
        e2_next[0] = EW'(v2_x) - EW'(v0_x);
        e2_next[1] = EW'(v2_y) - EW'(v0_y);
        e2_next[2] = EW'(v2_z) - EW'(v0_z);
    end

    // stage 2: six products
    logic signed [PW-1:0] p_reg  [6];
    logic signed [PW-1:0] p_next [6];
    logic                 s2_valid_reg;

    always_comb
    begin
        p_next[0] = PW'(e1_reg[1]) * PW'(e2_reg[2]);
        p_next[1] = PW'(e1_reg[2]) * PW'(e2_reg[1]);
        p_next[2] = PW'(e1_reg[2]) * PW'(e2_reg[0]);
        p_next[3] = PW'(e1_reg[0]) * PW'(e2_reg[2]);
        p_next[4] = PW'(e1_reg[0]) * PW'(e2_reg[1]);
        p_next[5] = PW'(e1_reg[1]) * PW'(e2_reg[0]);
    end

    // stage 3: cross product magnitudes and signs
    logic [2:0][MW-1:0]   mag3_reg;
    logic [2:0][MW-1:0]   mag3_next;
    logic [2:0]           neg3_reg;
    logic [2:0]           neg3_next;
    logic                 s3_valid_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            logic signed [CW-1:0] c;
            c = CW'(p_reg[2*i]) - CW'(p_reg[2*i+1]);
            neg3_next[i] = c[CW-1];
            mag3_next[i] = neg3_next[i] ? MW'(-c) : MW'(c);
        end
    end

    // stage 4: squares
    logic [SQW-1:0]       sq_reg  [3];
    logic [SQW-1:0]       sq_next [3];
    tfn_pkg::side_t       side4_reg;
    tfn_pkg::side_t       side4_next;
    logic                 s4_valid_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            sq_next[i] = SQW'(mag3_reg[i]) * SQW'(mag3_reg[i]);
        side4_next.mag = mag3_reg;
        side4_next.neg = neg3_reg;
        side4_next.deg = (mag3_reg == '0);
    end

    // stage 5: sum of squares
    logic [SW-1:0]        sum_reg;
    logic [SW-1:0]        sum_next;
    tfn_pkg::side_t       side5_reg;
    logic                 s5_valid_reg;

    assign sum_next = SW'(sq_reg[0]) + SW'(sq_reg[1]) + SW'(sq_reg[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start && !busy;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        e1_reg    <= e1_next;
        e2_reg    <= e2_next;
        p_reg     <= p_next;
        mag3_reg  <= mag3_next;
        neg3_reg  <= neg3_next;
        sq_reg    <= sq_next;
        side4_reg <= side4_next;
        sum_reg   <= sum_next;
        side5_reg <= side4_reg;
    end

    // square root pipeline
    logic                         root_valid;
    logic [tfn_pkg::ROOT_W-1:0]   root_len;
    tfn_pkg::side_t               root_side;

    tfn_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s5_valid_reg),
        .in_sum    (sum_reg),
        .in_side   (side5_reg),
        .out_valid (root_valid),
        .out_root  (root_len),
        .out_side  (root_side)
    );

    // divider pipeline
    tfn_pkg::sign_t       div_sign_in;
    tfn_pkg::sign_t       div_sign;
    logic                 div_valid;
    logic [2:0][QW-1:0]   div_q;

    assign div_sign_in.neg = root_side.neg;
    assign div_sign_in.deg = root_side.deg;

    tfn_udiv u_udiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (root_valid),
        .in_len    (root_len),
        .in_mag    (root_side.mag),
        .in_sign   (div_sign_in),
        .out_valid (div_valid),
        .out_q     (div_q),
        .out_sign  (div_sign)
    );

    // output register: clamp, sign, degenerate override
    logic [OW-1:0] n_reg  [3];
    logic [OW-1:0] n_next [3];
    logic          deg_reg;
    logic          done_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            logic [QW-1:0] q;
            q = (div_q[i] > tfn_pkg::NORM_ONE) ? tfn_pkg::NORM_ONE : div_q[i];
            if (div_sign.deg)
                n_next[i] = '0;
            else if (div_sign.neg[i])
                n_next[i] = OW'(-q);
            else
                n_next[i] = OW'(q);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= div_valid;
    end

    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        deg_reg <= div_sign.deg;
    end

    assign done       = done_reg;
    assign normal_x   = n_reg[0];
    assign normal_y   = n_reg[1];
    assign normal_z   = n_reg[2];
    assign degenerate = deg_reg;

endmodule

// ----- src/tfn_isqrt.sv -----
// pipelined integer square root, one result bit per stage
module tfn_isqrt (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic [tfn_pkg::SUM_W-1:0]    in_sum,
    input  tfn_pkg::side_t               in_side,
    output logic                         out_valid,
    output logic [tfn_pkg::ROOT_W-1:0]   out_root,
    output tfn_pkg::side_t               out_side
);

    localparam int N = tfn_pkg::ROOT_W;
    localparam int W = tfn_pkg::SUM_W;

    logic [W-1:0]   rem_reg  [N];
    logic [W-1:0]   res_reg  [N];
    tfn_pkg::side_t side_reg [N];
    logic [N-1:0]   valid_reg;

    genvar s;
    generate
        for (s = 0; s < N; s++)
        begin : g_stage
            localparam logic [W-1:0] BIT = W'(1) << (2 * (N - 1 - s));
            logic [W-1:0]   rem_in;
            logic [W-1:0]   res_in;
            tfn_pkg::side_t side_in;
            logic           valid_in;
            logic [W-1:0]   trial;
            logic           take;
            logic [W-1:0]   rem_next;
            logic [W-1:0]   res_next;

            if (s == 0)
            begin : g_first
                assign rem_in   = in_sum;
                assign res_in   = '0;
                assign side_in  = in_side;
                assign valid_in = in_valid;
            end
            else
            begin : g_rest
                assign rem_in   = rem_reg[s-1];
                assign res_in   = res_reg[s-1];
                assign side_in  = side_reg[s-1];
                assign valid_in = valid_reg[s-1];
            end

            always_comb
            begin
                trial    = res_in + BIT;
                take     = rem_in >= trial;
                rem_next = take ? rem_in - trial : rem_in;
                res_next = take ? (res_in >> 1) + BIT : res_in >> 1;
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    valid_reg[s] <= 1'b0;
                else
                    valid_reg[s] <= valid_in;
            end

            always_ff @(posedge clk)
            begin
                rem_reg[s]  <= rem_next;
                res_reg[s]  <= res_next;
                side_reg[s] <= side_in;
            end
        end
    endgenerate

    assign out_valid = valid_reg[N-1];
    assign out_root  = res_reg[N-1][N-1:0];
    assign out_side  = side_reg[N-1];

endmodule

// ----- src/tfn_udiv.sv -----
// three-lane pipelined restoring divider giving rounded unit components
module tfn_udiv (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic [tfn_pkg::ROOT_W-1:0]         in_len,
    input  logic [2:0][tfn_pkg::MAG_W-1:0]     in_mag,
    input  tfn_pkg::sign_t                     in_sign,
    output logic                               out_valid,
    output logic [2:0][tfn_pkg::Q_W-1:0]       out_q,
    output tfn_pkg::sign_t                     out_sign
);

    localparam int N = tfn_pkg::Q_W;
    localparam int W = tfn_pkg::NUM_W;

    logic [2:0][W-1:0]   num_reg  [N];
    logic [2:0][N-1:0]   q_reg    [N];
    logic [tfn_pkg::ROOT_W-1:0] len_reg [N];
    tfn_pkg::sign_t      sign_reg [N];
    logic [N-1:0]        valid_reg;

    genvar s;
    generate
        for (s = 0; s < N; s++)
        begin : g_stage
            localparam int K = N - 1 - s;
            logic [2:0][W-1:0]          num_in;
            logic [2:0][N-1:0]          q_in;
            logic [tfn_pkg::ROOT_W-1:0] len_in;
            tfn_pkg::sign_t             sign_in;
            logic                       valid_in;
            logic [W-1:0]               dvs;
            logic [2:0][W-1:0]          num_next;
            logic [2:0][N-1:0]          q_next;

            if (s == 0)
            begin : g_first
                // numerator carries the half-unit rounding term
                always_comb
                begin
                    for (int l = 0; l < 3; l++)
                        num_in[l] = (W'(in_mag[l]) << (tfn_pkg::FRAC_W + 1)) + W'(in_len);
                end
                assign q_in     = '0;
                assign len_in   = in_len;
                assign sign_in  = in_sign;
                assign valid_in = in_valid;
            end
            else
            begin : g_rest
                assign num_in   = num_reg[s-1];
                assign q_in     = q_reg[s-1];
                assign len_in   = len_reg[s-1];
                assign sign_in  = sign_reg[s-1];
                assign valid_in = valid_reg[s-1];
            end

            always_comb
            begin
                dvs = W'(len_in) << (K + 1);
                for (int l = 0; l < 3; l++)
                begin
                    if (num_in[l] >= dvs)
                    begin
                        num_next[l] = num_in[l] - dvs;
                        q_next[l]   = q_in[l] | (N'(1) << K);
                    end
                    else
                    begin
                        num_next[l] = num_in[l];
                        q_next[l]   = q_in[l];
                    end
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    valid_reg[s] <= 1'b0;
                else
                    valid_reg[s] <= valid_in;
            end

            always_ff @(posedge clk)
            begin
                num_reg[s]  <= num_next;
                q_reg[s]    <= q_next;
                len_reg[s]  <= len_in;
                sign_reg[s] <= sign_in;
            end
        end
    endgenerate

    assign out_valid = valid_reg[N-1];
    assign out_q     = q_reg[N-1];
    assign out_sign  = sign_reg[N-1];

endmodule
